// File: hdl/jsu_pkg.sv
// Package for the JSON string unescaper: word and bundle types, state codes,
// status codes and the UTF-8 and hex helper functions.
// Depends on nothing; every other file of the block imports it.
package jsu_pkg;

  // Decoder modes.
  localparam logic [2:0] MODE_WAITQ   = 3'd0;
  localparam logic [2:0] MODE_STR     = 3'd1;
  localparam logic [2:0] MODE_ESC     = 3'd2;
  localparam logic [2:0] MODE_HEX1    = 3'd3;
  localparam logic [2:0] MODE_HIGH    = 3'd4;
  localparam logic [2:0] MODE_HIGHESC = 3'd5;
  localparam logic [2:0] MODE_HEX2    = 3'd6;
  localparam logic [2:0] MODE_FIN     = 3'd7;

  // Status codes carried in a result word.
  localparam logic [2:0] STATUS_OK         = 3'd0;
  localparam logic [2:0] STATUS_BADESC     = 3'd1;
  localparam logic [2:0] STATUS_BADHEX     = 3'd2;
  localparam logic [2:0] STATUS_INCOMPLETE = 3'd3;
  localparam logic [2:0] STATUS_UNTERM     = 3'd4;
  localparam logic [2:0] STATUS_NOQUOTE    = 3'd5;

  // Most result words that one input word can cause.
  localparam int unsigned MaxWords = 4;

  // One result word.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic [2:0] status;
  } word_t;

  // The result words of one input word, in order, with their count.
  typedef struct packed {
    word_t [MaxWords-1:0] words;
    logic [2:0]           cnt;
  } bundle_t;

  // Decoder state.
  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] hex_acc;
    logic [1:0]  hex_cnt;
    logic [15:0] high_unit;
  } state_t;

  // A word that carries one decoded byte.
  function automatic word_t mk_byte(input logic [7:0] b);
    word_t w;
    w.out_byte    = b;
    w.byte_valid  = 1'b1;
    w.string_done = 1'b0;
    w.status      = STATUS_OK;
    return w;
  endfunction

  // A word that carries only a status or the done marker.
  function automatic word_t mk_mark(input logic done, input logic [2:0] st);
    word_t w;
    w.out_byte    = 8'h00;
    w.byte_valid  = 1'b0;
    w.string_done = done;
    w.status      = st;
    return w;
  endfunction

  // A bundle holding a single word.
  function automatic bundle_t mk_single(input word_t w);
    bundle_t b;
    b          = '0;
    b.words[0] = w;
    b.cnt      = 3'd1;
    return b;
  endfunction

  // UTF-8 encoding of a code point of up to 21 bits.
  function automatic bundle_t fn_utf8(input logic [20:0] cp);
    bundle_t b;
    b = '0;
    if (cp <= 21'h00007F) begin
      b.words[0] = mk_byte(cp[7:0]);
      b.cnt      = 3'd1;
    end else if (cp <= 21'h0007FF) begin
      b.words[0] = mk_byte(8'hC0 | {3'b000, cp[10:6]});
      b.words[1] = mk_byte(8'h80 | {2'b00, cp[5:0]});
      b.cnt      = 3'd2;
    end else if (cp <= 21'h00FFFF) begin
      b.words[0] = mk_byte(8'hE0 | {4'b0000, cp[15:12]});
      b.words[1] = mk_byte(8'h80 | {2'b00, cp[11:6]});
      b.words[2] = mk_byte(8'h80 | {2'b00, cp[5:0]});
      b.cnt      = 3'd3;
    end else begin
      b.words[0] = mk_byte(8'hF0 | {5'b00000, cp[20:18]});
      b.words[1] = mk_byte(8'h80 | {2'b00, cp[17:12]});
      b.words[2] = mk_byte(8'h80 | {2'b00, cp[11:6]});
      b.words[3] = mk_byte(8'h80 | {2'b00, cp[5:0]});
      b.cnt      = 3'd4;
    end
    return b;
  endfunction

  // Hex digit value; bit 4 is set for a byte that is no hex digit.
  function automatic logic [4:0] fn_hex(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = {1'b0, c[3:0] + 4'd9};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

endpackage

// File: hdl/jsu_decoder.sv
// Next-state and result logic of the unescaper: one input word and the
// current state give the next state and a bundle of up to four result words.
// Depends on jsu_pkg.
module jsu_decoder import jsu_pkg::*; (
  input  state_t     state_i,
  input  logic       action_i,
  input  logic [7:0] data_byte_i,
  output state_t     state_o,
  output bundle_t    bundle_o
);

  // A partial result: its words and the mode that follows.
  typedef struct packed {
    bundle_t    b;
    logic [2:0] mode;
  } step_t;

  // A byte inside the string proper.
  function automatic step_t fn_string(input logic [7:0] c);
    step_t s;
    s.b = '0;
    if (c == 8'h22) begin
      s.mode = MODE_FIN;
      s.b    = mk_single(mk_mark(1'b1, STATUS_OK));
    end else if (c == 8'h5C) begin
      s.mode = MODE_ESC;
    end else begin
      s.mode = MODE_STR;
      s.b    = mk_single(mk_byte(c));
    end
    return s;
  endfunction

  // The letter after a backslash; the u letter is handled by the caller.
  function automatic step_t fn_escape(input logic [7:0] c);
    step_t s;
    s.mode = MODE_STR;
    case (c)
      8'h22, 8'h5C, 8'h2F: s.b = mk_single(mk_byte(c));
      8'h62:               s.b = mk_single(mk_byte(8'h08));
      8'h66:               s.b = mk_single(mk_byte(8'h0C));
      8'h6E:               s.b = mk_single(mk_byte(8'h0A));
      8'h72:               s.b = mk_single(mk_byte(8'h0D));
      8'h74:               s.b = mk_single(mk_byte(8'h09));
      default: begin
        s.mode = MODE_FIN;
        s.b    = mk_single(mk_mark(1'b0, STATUS_BADESC));
      end
    endcase
    return s;
  endfunction

  logic        is_end;
  logic [7:0]  c;
  logic        is_ws;
  logic [4:0]  hex_v;
  logic [15:0] acc_n;
  logic [20:0] joined_cp;
  bundle_t     pre_b;
  logic        pre_en;
  step_t       main_s;

  assign is_end = action_i;
  assign c      = data_byte_i;
  assign is_ws  = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  assign hex_v  = fn_hex(c);
  assign acc_n  = {state_i.hex_acc[11:0], hex_v[3:0]};

  // Surrogate pair join; the high unit lies in D800..DBFF, so its low ten
  // bits are its offset, and the sum always fits in 21 bits.
  assign joined_cp = 21'h010000 + {1'b0, state_i.high_unit[9:0], 10'b0}
                   + {5'b0, acc_n} - 21'h00DC00;

  // The three bytes of a pending high surrogate.
  assign pre_b = fn_utf8({5'b0, state_i.high_unit});

  // Mode decode.
  always_comb begin
    state_o     = state_i;
    pre_en      = 1'b0;
    main_s      = '0;
    main_s.mode = state_i.mode;
    unique case (state_i.mode)
      MODE_WAITQ: begin
        if (is_end || !(is_ws || c == 8'h22)) begin
          main_s.mode = MODE_FIN;
          main_s.b    = mk_single(mk_mark(1'b0, STATUS_NOQUOTE));
        end else if (c == 8'h22) begin
          main_s.mode = MODE_STR;
        end
      end
      MODE_STR: begin
        if (is_end) begin
          main_s.mode = MODE_FIN;
          main_s.b    = mk_single(mk_mark(1'b0, STATUS_UNTERM));
        end else begin
          main_s = fn_string(c);
        end
      end
      MODE_ESC: begin
        if (is_end) begin
          main_s.mode = MODE_FIN;
          main_s.b    = mk_single(mk_mark(1'b0, STATUS_UNTERM));
        end else if (c == 8'h75) begin
          main_s.mode     = MODE_HEX1;
          state_o.hex_acc = 16'h0000;
          state_o.hex_cnt = 2'd0;
        end else begin
          main_s = fn_escape(c);
        end
      end
      MODE_HEX1, MODE_HEX2: begin
        if (is_end) begin
          main_s.mode = MODE_FIN;
          main_s.b    = mk_single(mk_mark(1'b0, STATUS_INCOMPLETE));
        end else if (hex_v[4]) begin
          main_s.mode = MODE_FIN;
          main_s.b    = mk_single(mk_mark(1'b0, STATUS_BADHEX));
        end else begin
          state_o.hex_acc = acc_n;
          if (state_i.hex_cnt != 2'd3) begin
            state_o.hex_cnt = state_i.hex_cnt + 2'd1;
          end else begin
            state_o.hex_cnt = 2'd0;
            if (state_i.mode == MODE_HEX1) begin
              if (acc_n >= 16'hD800 && acc_n <= 16'hDBFF) begin
                state_o.high_unit = acc_n;
                main_s.mode       = MODE_HIGH;
              end else begin
                main_s.mode = MODE_STR;
                main_s.b    = fn_utf8({5'b0, acc_n});
              end
            end else begin
              main_s.mode = MODE_STR;
              main_s.b    = fn_utf8(joined_cp);
            end
          end
        end
      end
      MODE_HIGH: begin
        if (!is_end && c == 8'h5C) begin
          main_s.mode = MODE_HIGHESC;
        end else begin
          pre_en = 1'b1;
          if (is_end) begin
            main_s.mode = MODE_FIN;
            main_s.b    = mk_single(mk_mark(1'b0, STATUS_UNTERM));
          end else begin
            main_s = fn_string(c);
          end
        end
      end
      MODE_HIGHESC: begin
        if (!is_end && c == 8'h75) begin
          main_s.mode     = MODE_HEX2;
          state_o.hex_acc = 16'h0000;
          state_o.hex_cnt = 2'd0;
        end else begin
          pre_en = 1'b1;
          if (is_end) begin
            main_s.mode = MODE_FIN;
            main_s.b    = mk_single(mk_mark(1'b0, STATUS_UNTERM));
          end else begin
            main_s = fn_escape(c);
          end
        end
      end
      default: begin
        main_s.mode = MODE_FIN;
      end
    endcase
    state_o.mode = main_s.mode;
  end

  // Put the lone surrogate bytes ahead of the main result when needed.
  always_comb begin
    if (pre_en) begin
      bundle_o.words[0] = pre_b.words[0];
      bundle_o.words[1] = pre_b.words[1];
      bundle_o.words[2] = pre_b.words[2];
      bundle_o.words[3] = main_s.b.words[0];
      bundle_o.cnt      = 3'd3 + main_s.b.cnt;
    end else begin
      bundle_o = main_s.b;
    end
  end

endmodule

// File: hdl/jsu_out_buffer.sv
// Result register of the unescaper: holds the bundle of one input word and
// hands its words out one per cycle on the output channel while it does not stall.
// Depends on jsu_pkg.
module jsu_out_buffer import jsu_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  bundle_t bundle_i,
  output logic    ready_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output word_t   word_o,
  output logic    last_o
);

  word_t [MaxWords-1:0] words_q;
  logic [2:0]           cnt_q, cnt_d;
  logic [1:0]           idx_q, idx_d;
  logic                 take;

  assign out_valid_o = (cnt_q != 3'd0);
  assign word_o      = words_q[idx_q];
  assign last_o      = ({1'b0, idx_q} == (cnt_q - 3'd1));
  assign take        = out_valid_o && !out_stall_i;
  assign ready_o     = !out_valid_o || (take && last_o);

  // Word pointer and fill count.
  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load_i) begin
      cnt_d = bundle_i.cnt;
      idx_d = 2'd0;
    end else if (take) begin
      if (last_o) begin
        cnt_d = 3'd0;
        idx_d = 2'd0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
      idx_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  // Payload words need no reset.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      words_q <= bundle_i.words;
    end
  end

  // The pointer stays inside the loaded bundle.
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, idx_q} < cnt_q))
    else $error("word pointer beyond bundle");

  // A bundle is never loaded over words still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> ready_o)
    else $error("bundle loaded while words pending");

  // A fresh bundle starts at its first word.
  a_load_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> (out_valid_o && idx_q == 2'd0))
    else $error("loaded bundle does not start at first word");

  // A taken word that is not the last is followed by the next one.
  a_burst_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !last_o) |=> (out_valid_o && idx_q == $past(idx_q) + 2'd1))
    else $error("burst did not advance");

endmodule

// File: hdl/json_string_unescaper_unit.sv
// Top level of the JSON string unescaper: state register, decoder and result
// buffer. Depends on jsu_pkg, jsu_decoder and jsu_out_buffer.
//
//   channel | handshake              | payload
//   --------+------------------------+---------------------------------------------
//   input   | in_valid_i, in_stall_o | action_i, data_byte_i
//   output  | out_valid_o, out_stall_i | out_byte_o, byte_valid_o, string_done_o,
//           |                        | status_o, last_o
//
// An input word is decoded in the cycle it is accepted and its results show
// on the output from the next cycle. A word with at most one result leaves
// the input free every cycle; a word with more results holds the input until
// its last goes out; unstalled, the result buffer hands out one word a cycle.
// Reset puts the decoder back to waiting for the opening quote; no clearing
// pass. Output stalls hold the current word and back up into the input.
module json_string_unescaper_unit import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       action_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       string_done_o,
  output logic [2:0] status_o,
  output logic       last_o
);

  state_t  state_q, state_d;
  bundle_t bundle;
  word_t   word;
  logic    ready;
  logic    accept;

  assign in_stall_o = !ready;
  assign accept     = in_valid_i && ready;

  // Decode of the current input word.
  jsu_decoder u_decoder (
    .state_i     (state_q),
    .action_i    (action_i),
    .data_byte_i (data_byte_i),
    .state_o     (state_d),
    .bundle_o    (bundle)
  );

  // Decoder state advances on every accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode      <= MODE_WAITQ;
      state_q.hex_acc   <= 16'h0000;
      state_q.hex_cnt   <= 2'd0;
      state_q.high_unit <= 16'h0000;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  // Result buffer between decoder and output channel.
  jsu_out_buffer u_out_buffer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept && (bundle.cnt != 3'd0)),
    .bundle_i    (bundle),
    .ready_o     (ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .word_o      (word),
    .last_o      (last_o)
  );

  assign out_byte_o    = word.out_byte;
  assign byte_valid_o  = word.byte_valid;
  assign string_done_o = word.string_done;
  assign status_o      = word.status;

endmodule

// File: tb/tb.sv
// Testbench for json_string_unescaper_unit: one quoted string with escapes, UTF-16
// code units and one randomly chosen ending, checked word by word against a predictor.
// Depends on jsu_pkg and the json_string_unescaper_unit RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  // Run limit in clock cycles.
  localparam int unsigned CYCLE_LIMIT = 200000;

  // Input word actions.
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // Characters that steer the decoder.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_A      = 8'h41;

  // How the string ends.
  typedef enum int {
    END_NOQUOTE, END_CLOSE, END_BADESC, END_BADHEX, END_HEXEOF, END_STREOF,
    END_ESCEOF, END_HIGHEOF, END_HIGHESCEOF, END_HIGHCLOSE, END_HIGHBADESC
  } ending_e;

  typedef struct packed {
    logic       action;
    logic [7:0] data;
  } text_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic [2:0] status;
    logic       last;
  } decoded_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       action_i      = ACT_BYTE;
  logic [7:0] data_byte_i   = 8'h00;
  logic       out_stall_i   = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       string_done_o;
  logic [2:0] status_o;
  logic       last_o;

  text_word_t  text_q[$];
  decoded_t    decoded_q[$];
  int unsigned words_total    = 0;
  int unsigned words_accepted = 0;
  int unsigned words_checked  = 0;
  int unsigned fail_count     = 0;
  int unsigned cycle_count    = 0;

  // Predictor state.
  logic [2:0]  dec_mode  = MODE_WAITQ;
  logic [15:0] hex_acc   = 16'h0000;
  logic [1:0]  hex_cnt   = 2'd0;
  logic [15:0] high_unit = 16'h0000;

  json_string_unescaper_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .string_done_o (string_done_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    fail_count++;
  endtask

  // Hex digit value; bit 4 marks a byte that is no hex digit.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if (c >= 8'h61 && c <= 8'h66) return {1'b0, 4'(c - 8'h57)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b0, 4'(c - 8'h37)};
    return 5'h10;
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void push_result(input logic [7:0] b, input logic bv, input logic dn,
                                      input logic [2:0] st);
    decoded_t r;
    r.out_byte    = b;
    r.byte_valid  = bv;
    r.string_done = dn;
    r.status      = st;
    r.last        = 1'b0;
    decoded_q = {decoded_q, r};
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    push_result(b, 1'b1, 1'b0, STATUS_OK);
  endfunction

  // An error ends the string for good.
  function automatic void end_with(input logic [2:0] st);
    dec_mode = MODE_FIN;
    push_result(8'h00, 1'b0, 1'b0, st);
  endfunction

  // UTF-8 bytes of a code point; lead bytes keep only their low 8 bits.
  function automatic void push_utf8(input logic [31:0] cp);
    logic [31:0] lead;
    if (cp <= 32'h7F) begin
      push_byte(cp[7:0]);
    end else if (cp <= 32'h7FF) begin
      lead = 32'hC0 | (cp >> 6);
      push_byte(lead[7:0]);
      push_byte(8'h80 | {2'b00, cp[5:0]});
    end else if (cp <= 32'hFFFF) begin
      lead = 32'hE0 | (cp >> 12);
      push_byte(lead[7:0]);
      push_byte(8'h80 | {2'b00, cp[11:6]});
      push_byte(8'h80 | {2'b00, cp[5:0]});
    end else begin
      lead = 32'hF0 | (cp >> 18);
      push_byte(lead[7:0]);
      push_byte(8'h80 | {2'b00, cp[17:12]});
      push_byte(8'h80 | {2'b00, cp[11:6]});
      push_byte(8'h80 | {2'b00, cp[5:0]});
    end
  endfunction

  function automatic void string_byte(input logic [7:0] c);
    if (c == CH_QUOTE) begin
      dec_mode = MODE_FIN;
      push_result(8'h00, 1'b0, 1'b1, STATUS_OK);
    end else if (c == CH_BSLASH) begin
      dec_mode = MODE_ESC;
    end else begin
      push_byte(c);
    end
  endfunction

  function automatic void escape_byte(input logic [7:0] c);
    logic [7:0] v;
    logic       simple;
    v      = c;
    simple = 1'b1;
    case (c)
      CH_QUOTE, CH_BSLASH, CH_SLASH: v = c;
      CH_B: v = 8'h08;
      CH_F: v = 8'h0C;
      CH_N: v = 8'h0A;
      CH_R: v = 8'h0D;
      CH_T: v = 8'h09;
      CH_U: begin
        simple   = 1'b0;
        dec_mode = MODE_HEX1;
        hex_acc  = 16'h0000;
        hex_cnt  = 2'd0;
      end
      default: begin
        simple = 1'b0;
        end_with(STATUS_BADESC);
      end
    endcase
    if (simple) begin
      dec_mode = MODE_STR;
      push_byte(v);
    end
  endfunction

  // One digit of a \uXXXX; the fourth digit completes a unit or a joined pair.
  function automatic void hex_digit(input logic [7:0] c);
    logic [4:0]  d;
    logic [31:0] cp;
    d = hex_nibble(c);
    if (d[4]) begin
      end_with(STATUS_BADHEX);
    end else begin
      hex_acc = {hex_acc[11:0], d[3:0]};
      if (hex_cnt < 2'd3) begin
        hex_cnt = hex_cnt + 2'd1;
      end else begin
        hex_cnt = 2'd0;
        if (dec_mode == MODE_HEX1) begin
          if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
            high_unit = hex_acc;
            dec_mode  = MODE_HIGH;
          end else begin
            dec_mode = MODE_STR;
            push_utf8({16'h0000, hex_acc});
          end
        end else begin
          // The second unit is joined without checking that it is a low surrogate.
          cp = 32'h10000 + (({16'h0000, high_unit} - 32'hD800) << 10)
             + ({16'h0000, hex_acc} - 32'hDC00);
          dec_mode = MODE_STR;
          push_utf8(cp);
        end
      end
    end
  endfunction

  // Predicts the result words of one accepted input word.
  function automatic void unescape_step(input logic endm, input logic [7:0] c);
    int       n0;
    decoded_t r;
    n0 = decoded_q.size();
    case (dec_mode)
      MODE_WAITQ: begin
        if (endm) end_with(STATUS_NOQUOTE);
        else if (c == CH_SPACE || (c >= 8'h09 && c <= CH_CR)) ;
        else if (c == CH_QUOTE) dec_mode = MODE_STR;
        else end_with(STATUS_NOQUOTE);
      end
      MODE_STR: begin
        if (endm) end_with(STATUS_UNTERM);
        else string_byte(c);
      end
      MODE_ESC: begin
        if (endm) end_with(STATUS_UNTERM);
        else escape_byte(c);
      end
      MODE_HEX1, MODE_HEX2: begin
        if (endm) end_with(STATUS_INCOMPLETE);
        else hex_digit(c);
      end
      MODE_HIGH: begin
        if (!endm && c == CH_BSLASH) begin
          dec_mode = MODE_HIGHESC;
        end else begin
          // Lone high surrogate: emit it, then handle this word as the string mode would.
          push_utf8({16'h0000, high_unit});
          dec_mode = MODE_STR;
          if (endm) end_with(STATUS_UNTERM);
          else string_byte(c);
        end
      end
      MODE_HIGHESC: begin
        if (!endm && c == CH_U) begin
          dec_mode = MODE_HEX2;
          hex_acc  = 16'h0000;
          hex_cnt  = 2'd0;
        end else begin
          push_utf8({16'h0000, high_unit});
          if (endm) end_with(STATUS_UNTERM);
          else escape_byte(c);
        end
      end
      default: ;
    endcase
    if (decoded_q.size() > n0) begin
      r      = decoded_q[decoded_q.size() - 1];
      r.last = 1'b1;
      decoded_q[decoded_q.size() - 1] = r;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void add_word(input logic act, input logic [7:0] b);
    text_word_t w;
    w.action = act;
    w.data   = b;
    text_q = {text_q, w};
  endfunction

  // The top n hex digits of v, letters in random case.
  function automatic void add_hex_digits(input logic [15:0] v, input int n);
    logic [3:0] nib;
    for (int i = 0; i < n; i++) begin
      nib = v[15-4*i -: 4];
      if (nib < 4'd10) add_word(ACT_BYTE, 8'h30 + {4'h0, nib});
      else if ($urandom_range(0, 1) == 0) add_word(ACT_BYTE, 8'h37 + {4'h0, nib});
      else add_word(ACT_BYTE, 8'h57 + {4'h0, nib});
    end
  endfunction

  function automatic void add_unicode(input logic [15:0] v);
    add_word(ACT_BYTE, CH_BSLASH);
    add_word(ACT_BYTE, CH_U);
    add_hex_digits(v, 4);
  endfunction

  function automatic logic [7:0] rand_plain();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  function automatic logic [7:0] rand_escape_letter();
    case ($urandom_range(0, 7))
      0: return CH_QUOTE;
      1: return CH_BSLASH;
      2: return CH_SLASH;
      3: return CH_B;
      4: return CH_F;
      5: return CH_N;
      6: return CH_R;
      default: return CH_T;
    endcase
  endfunction

  function automatic logic [7:0] rand_bad_letter();
    logic [7:0] c;
    logic       ok;
    c  = 8'h00;
    ok = 1'b0;
    while (!ok) begin
      c = 8'($urandom_range(0, 255));
      case (c)
        CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U: ok = 1'b0;
        default: ok = 1'b1;
      endcase
    end
    return c;
  endfunction

  function automatic logic [15:0] rand_high();
    return 16'hD800 + 16'($urandom_range(0, 16'h03FF));
  endfunction

  function automatic logic [15:0] rand_unit();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 16'h007F));
      1: return 16'($urandom_range(16'h0080, 16'h07FF));
      2: return 16'($urandom_range(16'h0800, 16'hFFFF));
      3: return 16'($urandom_range(16'hDC00, 16'hDFFF));
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sequence, reset and end of run
  // ---------------------------------------------------------------------------

  initial begin
    ending_e     ending;
    int          n;
    int          body_end;
    logic [7:0]  b;
    logic [4:0]  nib;

    // Leading whitespace.
    add_word(ACT_BYTE, CH_SPACE);
    add_word(ACT_BYTE, CH_CR);
    n = $urandom_range(0, 2);
    repeat (n) begin
      b = 8'($urandom_range(8'h09, 8'h0E));
      add_word(ACT_BYTE, (b == 8'h0E) ? CH_SPACE : b);
    end

    ending = ending_e'($urandom_range(END_NOQUOTE, END_HIGHBADESC));
    if (ending == END_NOQUOTE) begin
      // Missing opening quote: end of text or any other byte.
      if ($urandom_range(0, 1) == 0) begin
        add_word(ACT_END, 8'($urandom_range(0, 255)));
      end else begin
        do begin
          b = 8'($urandom_range(0, 255));
        end while (b == CH_SPACE || (b >= 8'h09 && b <= CH_CR) || b == CH_QUOTE);
        add_word(ACT_BYTE, b);
      end
    end else begin
      add_word(ACT_BYTE, CH_QUOTE);

      // Directed: byte extremes, the largest joined pair, a lone high surrogate.
      add_word(ACT_BYTE, 8'h00);
      add_word(ACT_BYTE, 8'hFF);
      add_unicode(16'hDBFF);
      add_unicode(16'hDFFF);
      add_unicode(16'hD800);
      add_word(ACT_BYTE, CH_A);

      // Random well-formed string content.
      body_end = text_q.size() + 150;
      while (text_q.size() < body_end) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: add_word(ACT_BYTE, rand_plain());
          4, 5: begin
            add_word(ACT_BYTE, CH_BSLASH);
            add_word(ACT_BYTE, rand_escape_letter());
          end
          6, 9: add_unicode(rand_unit());
          7: begin
            add_unicode(rand_high());
            if ($urandom_range(0, 3) == 0) add_unicode(16'($urandom_range(0, 16'hFFFF)));
            else add_unicode(16'($urandom_range(16'hDC00, 16'hDFFF)));
          end
          default: begin
            add_unicode(rand_high());
            if ($urandom_range(0, 1) == 0) begin
              add_word(ACT_BYTE, rand_plain());
            end else begin
              add_word(ACT_BYTE, CH_BSLASH);
              add_word(ACT_BYTE, rand_escape_letter());
            end
          end
        endcase
      end

      // The ending of the string.
      case (ending)
        END_CLOSE: add_word(ACT_BYTE, CH_QUOTE);
        END_BADESC: begin
          add_word(ACT_BYTE, CH_BSLASH);
          add_word(ACT_BYTE, rand_bad_letter());
        end
        END_BADHEX, END_HEXEOF: begin
          if ($urandom_range(0, 1) == 0) add_unicode(rand_high());
          add_word(ACT_BYTE, CH_BSLASH);
          add_word(ACT_BYTE, CH_U);
          add_hex_digits(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3));
          if (ending == END_HEXEOF) begin
            add_word(ACT_END, 8'($urandom_range(0, 255)));
          end else begin
            do begin
              b   = 8'($urandom_range(0, 255));
              nib = hex_nibble(b);
            end while (!nib[4]);
            add_word(ACT_BYTE, b);
          end
        end
        END_STREOF: add_word(ACT_END, 8'($urandom_range(0, 255)));
        END_ESCEOF: begin
          add_word(ACT_BYTE, CH_BSLASH);
          add_word(ACT_END, 8'($urandom_range(0, 255)));
        end
        END_HIGHEOF: begin
          add_unicode(rand_high());
          add_word(ACT_END, 8'($urandom_range(0, 255)));
        end
        END_HIGHESCEOF: begin
          add_unicode(rand_high());
          add_word(ACT_BYTE, CH_BSLASH);
          add_word(ACT_END, 8'($urandom_range(0, 255)));
        end
        END_HIGHCLOSE: begin
          add_unicode(rand_high());
          add_word(ACT_BYTE, CH_QUOTE);
        end
        default: begin
          add_unicode(rand_high());
          add_word(ACT_BYTE, CH_BSLASH);
          add_word(ACT_BYTE, rand_bad_letter());
        end
      endcase
    end

    // Words after the end must give no result; a short run gets a long tail.
    repeat ((ending == END_NOQUOTE) ? 150 : 8)
      add_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    words_total = text_q.size();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Drain: every word sent, every result seen, then a short tail.
    while (words_accepted != words_total) @(negedge clk_i);
    while (decoded_q.size() != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("** json_string_unescaper_unit: PASSED **");
    end else begin
      $display("** json_string_unescaper_unit: FAILED **");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver and stall generator, both at the falling edge
  // ---------------------------------------------------------------------------

  logic        in_taken  = 1'b0;
  logic        out_taken = 1'b0;
  logic        in_holding = 1'b0;
  logic        in_burst   = 1'b0;
  logic        out_burst  = 1'b0;
  int unsigned in_gap     = 0;
  int unsigned out_hold   = 0;
  text_word_t  next_word;

  // Input word driver with a random gap after each accepted word.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        in_holding = 1'b0;
        if ($urandom_range(0, 19) == 0) in_burst = !in_burst;
        in_gap = in_burst ? 0 : $urandom_range(0, 15);
      end
      if (!in_holding) begin
        if (in_gap != 0) begin
          in_gap--;
        end else if (text_q.size() != 0) begin
          next_word   = text_q.pop_front();
          action_i    <= next_word.action;
          data_byte_i <= next_word.data;
          in_holding  = 1'b1;
        end
      end
      in_valid_i <= in_holding;
    end
  end

  // Output stall: a random hold after each accepted result word.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        if ($urandom_range(0, 19) == 0) out_burst = !out_burst;
        out_hold = out_burst ? 0 : $urandom_range(0, 15);
      end
      if (out_hold != 0) begin
        out_stall_i <= 1'b1;
        out_hold--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor at the rising edge: predict accepted input words, check result words
  // ---------------------------------------------------------------------------

  decoded_t want;

  always @(posedge clk_i) begin
    in_taken  <= in_valid_i && !in_stall_o;
    out_taken <= out_valid_o && !out_stall_i;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (decoded_q.size() == 0) begin
          report($sformatf({"unexpected word %0d: byte %02h valid %0b done %0b",
                            " status %0d last %0b"},
                           words_checked, out_byte_o, byte_valid_o, string_done_o, status_o,
                           last_o));
        end else begin
          want = decoded_q.pop_front();
          if (out_byte_o !== want.out_byte)
            report($sformatf("word %0d: out_byte %02h, expected %02h",
                             words_checked, out_byte_o, want.out_byte));
          if (byte_valid_o !== want.byte_valid)
            report($sformatf("word %0d: byte_valid %0b, expected %0b",
                             words_checked, byte_valid_o, want.byte_valid));
          if (string_done_o !== want.string_done)
            report($sformatf("word %0d: string_done %0b, expected %0b",
                             words_checked, string_done_o, want.string_done));
          if (status_o !== want.status)
            report($sformatf("word %0d: status %0d, expected %0d",
                             words_checked, status_o, want.status));
          if (last_o !== want.last)
            report($sformatf("word %0d: last %0b, expected %0b",
                             words_checked, last_o, want.last));
        end
        words_checked++;
      end
      if (in_valid_i && !in_stall_o) begin
        unescape_step(action_i, data_byte_i);
        words_accepted++;
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** json_string_unescaper_unit: FAILED **");
      $finish;
    end
  end

endmodule

// File: sim.f
hdl/jsu_pkg.sv
hdl/jsu_decoder.sv
hdl/jsu_out_buffer.sv
hdl/json_string_unescaper_unit.sv
tb/tb.sv
